// ----- sv/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, skipped while reset is held
`define SCF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication checked on the following cycle
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/scf_pkg.sv -----
`default_nettype none
package scf_pkg;

    // input kinds
    localparam logic [2:0] KIND_WORD    = 3'd0;
    localparam logic [2:0] KIND_FLOAT   = 3'd1;
    localparam logic [2:0] KIND_PART    = 3'd2;
    localparam logic [2:0] KIND_READ    = 3'd3;
    localparam logic [2:0] KIND_RESTART = 3'd4;

    localparam logic [31:0] NEG_ZERO = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last;
    } out_item_t;

    // commands passed from front to back
    typedef enum logic [1:0] {
        OP_WORD  = 2'd0,
        OP_PARTS = 2'd1,
        OP_READ  = 2'd2,
        OP_SEED  = 2'd3
    } op_t;

    typedef struct packed {
        op_t          op;
        logic [255:0] data;
    } cmd_t;

    // domain string, padded to one block, length 224 bits
    localparam logic [223:0] DOMAIN_BYTES =
        224'h686f726f_2e6e6176_2e62616b_652e696e_7075742e_76310000_00000001;
    localparam logic [511:0] SEED_BLOCK =
        {DOMAIN_BYTES, 32'h8000_0000, 192'd0, 64'd224};
    // second block of a 64-byte message
    localparam logic [511:0] PAD_BLOCK = {32'h8000_0000, 416'd0, 64'd512};
    localparam logic [63:0] WORD_MSG_BITS = 64'd320;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sm_s0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sm_s1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage
`default_nettype wire

// ----- sv/sha256_chained_fingerprint_top.sv -----
// word or float absorb: one block of 64 rounds, one round per cycle, plus load and add
// digest parts: the first three are only staged in the front; the fourth costs two blocks
// read: four result words on consecutive cycles while m_ready holds, once the hash core is idle
// throughput is bound by the single shared round unit; a 2-entry command queue decouples input
// reset (aresetn, synchronous, active low) clears control, then the core hashes the domain
// seed; restart repeats that pass. items queue meanwhile
`default_nettype none
module sha256_chained_fingerprint_top
    import scf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    logic q_push, q_full, q_pop, q_valid;
    cmd_t push_cmd, pop_cmd;

    // classify transfers and stage digest parts
    scf_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    // command queue between front and hash core
    scf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (pop_cmd)
    );

    // hash core and digest readout
    scf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (pop_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// ----- sv/scf_front.sv -----
`default_nettype none
module scf_front
    import scf_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    input  wire logic     q_full,
    output logic          q_push,
    output cmd_t          q_cmd
);

    logic [1:0]  part_count_reg, part_count_next;
    logic [63:0] staged_reg [3];
    logic        accept;
    logic [31:0] float_bits;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign float_bits = (s_data.data_word[31:0] == NEG_ZERO) ? 32'd0
                                                             : s_data.data_word[31:0];

    // classify the transfer into a back-end command
    always_comb begin
        q_push          = 1'b0;
        q_cmd.op        = OP_WORD;
        q_cmd.data      = {192'd0, s_data.data_word};
        part_count_next = part_count_reg;
        if (accept) begin
            unique case (s_data.kind)
                KIND_WORD: begin
                    q_push = 1'b1;
                end
                KIND_FLOAT: begin
                    q_push     = 1'b1;
                    q_cmd.data = {224'd0, float_bits};
                end
                KIND_PART: begin
                    if (part_count_reg == 2'd3) begin
                        q_push          = 1'b1;
                        q_cmd.op        = OP_PARTS;
                        q_cmd.data      = {staged_reg[0], staged_reg[1], staged_reg[2],
                                           s_data.data_word};
                        part_count_next = 2'd0;
                    end else begin
                        part_count_next = part_count_reg + 2'd1;
                    end
                end
                KIND_READ: begin
                    q_push   = 1'b1;
                    q_cmd.op = OP_READ;
                end
                KIND_RESTART: begin
                    q_push          = 1'b1;
                    q_cmd.op        = OP_SEED;
                    part_count_next = 2'd0;
                end
                default: begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_count_reg <= 2'd0;
        end else begin
            part_count_reg <= part_count_next;
        end
    end

    // stage the first three digest parts
    always_ff @(posedge aclk) begin
        if (accept && s_data.kind == KIND_PART && part_count_reg != 2'd3) begin
            staged_reg[part_count_reg] <= s_data.data_word;
        end
    end

endmodule
`default_nettype wire

// ----- sv/scf_queue.sv -----
`default_nettype none
`include "assert_macros.svh"
module scf_queue
    import scf_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      pop_valid,
    output cmd_t      pop_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `SCF_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "queue count beyond depth")

endmodule
`default_nettype wire

// ----- sv/scf_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module scf_back
    import scf_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    input  wire cmd_t q_cmd,
    output logic      q_pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_item_t m_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_FIN   = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t       state_reg, state_next;
    logic         seed_pend_reg, seed_pend_next;
    logic         second_reg, second_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic [1:0]   rd_idx_reg, rd_idx_next;
    logic         m_valid_reg, m_valid_next;
    out_item_t    m_data_reg, m_data_next;
    logic [255:0] digest_reg, digest_next;
    logic [31:0]  h_reg [8];
    logic [31:0]  h_next [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  v_next [8];
    logic [31:0]  w_reg [16];
    logic [31:0]  w_next [16];

    logic [31:0]  t1, t2, ch, mj, w_new;
    logic [31:0]  h_sum [8];
    logic [511:0] blk;
    logic         start, out_load;

    // one compression round and the schedule word it needs later
    always_comb begin
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        mj    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + big_s1(v_reg[4]) + ch + ROUND_K[rnd_reg] + w_reg[0];
        t2    = big_s0(v_reg[0]) + mj;
        w_new = w_reg[0] + sm_s0(w_reg[1]) + w_reg[9] + sm_s1(w_reg[14]);
        for (int i = 0; i < 8; i++) begin
            h_sum[i] = h_reg[i] + v_reg[i];
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        seed_pend_next = seed_pend_reg;
        second_next    = second_reg;
        rnd_next       = rnd_reg;
        rd_idx_next    = rd_idx_reg;
        digest_next    = digest_reg;
        h_next         = h_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        q_pop          = 1'b0;
        start          = 1'b0;
        out_load       = 1'b0;
        blk            = SEED_BLOCK;

        unique case (state_reg)
            ST_IDLE: begin
                if (seed_pend_reg) begin
                    start          = 1'b1;
                    seed_pend_next = 1'b0;
                    second_next    = 1'b0;
                end else if (q_valid) begin
                    q_pop = 1'b1;
                    unique case (q_cmd.op)
                        OP_WORD: begin
                            start       = 1'b1;
                            second_next = 1'b0;
                            blk         = {digest_reg, q_cmd.data[63:0], NEG_ZERO, 96'd0,
                                           WORD_MSG_BITS};
                        end
                        OP_PARTS: begin
                            start       = 1'b1;
                            second_next = 1'b1;
                            blk         = {digest_reg, q_cmd.data};
                        end
                        OP_SEED: begin
                            start       = 1'b1;
                            second_next = 1'b0;
                        end
                        OP_READ: begin
                            rd_idx_next = 2'd0;
                            state_next  = ST_OUT;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
                if (start) begin
                    h_next     = INIT_H;
                    v_next     = INIT_H;
                    rnd_next   = 6'd0;
                    state_next = ST_ROUND;
                    for (int i = 0; i < 16; i++) begin
                        w_next[i] = blk[511 - 32*i -: 32];
                    end
                end
            end
            ST_ROUND: begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                for (int i = 0; i < 15; i++) begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[15] = w_new;
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (second_reg) begin
                    h_next      = h_sum;
                    v_next      = h_sum;
                    second_next = 1'b0;
                    rnd_next    = 6'd0;
                    state_next  = ST_ROUND;
                    for (int i = 0; i < 16; i++) begin
                        w_next[i] = PAD_BLOCK[511 - 32*i -: 32];
                    end
                end else begin
                    digest_next = {h_sum[0], h_sum[1], h_sum[2], h_sum[3],
                                   h_sum[4], h_sum[5], h_sum[6], h_sum[7]};
                    state_next  = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load    = 1'b1;
                    rd_idx_next = rd_idx_reg + 2'd1;
                    if (rd_idx_reg == 2'd3) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_data_next = m_data_reg;
        if (out_load) begin
            m_valid_next            = 1'b1;
            m_data_next.digest_word = digest_reg[255 - 64*rd_idx_reg -: 64];
            m_data_next.word_index  = rd_idx_reg;
            m_data_next.last        = (rd_idx_reg == 2'd3);
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            seed_pend_reg <= 1'b1;
            second_reg    <= 1'b0;
            rnd_reg       <= 6'd0;
            rd_idx_reg    <= 2'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            seed_pend_reg <= seed_pend_next;
            second_reg    <= second_next;
            rnd_reg       <= rnd_next;
            rd_idx_reg    <= rd_idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        digest_reg <= digest_next;
        h_reg      <= h_next;
        v_reg      <= v_next;
        w_reg      <= w_next;
        m_data_reg <= m_data_next;
    end

    `SCF_ASSERT_NEXT(a_round_end, state_reg == ST_ROUND && rnd_reg == 6'd63, state_reg == ST_FIN, "round 63 not followed by finish")
    `SCF_ASSERT(a_last_index, !m_valid_reg || (m_data_reg.last == (m_data_reg.word_index == 2'd3)), "last flag disagrees with word index")
    `SCF_ASSERT(a_pop_idle, !q_pop || (state_reg == ST_IDLE && !seed_pend_reg), "command taken while busy")

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import scf_pkg::*;

    localparam int IDLE_LIMIT = 6000;
    localparam int TAIL_CYCLES = 300;
    localparam int HOLD_CYCLES = 500;
    localparam int RANDOM_ITEMS = 500;
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [255:0] IV =
        256'h6a09e667_bb67ae85_3c6ef372_a54ff53a_510e527f_9b05688c_1f83d9ab_5be0cd19;
    localparam logic [223:0] DOMAIN =
        224'h686f726f_2e6e6176_2e62616b_652e696e_7075742e_76310000_00000001;

    typedef struct {
        in_item_t item;
        bit       drain;
    } pend_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    pend_t     pend_q[$];
    out_item_t digest_words_q[$];

    // predictor state
    logic [255:0] chain_q;
    logic [63:0]  parts_q [3];
    int           part_cnt;

    int errors = 0;
    int items_sent = 0;
    int words_checked = 0;
    int reads_sent = 0;
    bit stimulus_done = 0;

    sha256_chained_fingerprint_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one compression of a 512-bit block onto a chaining value
    function automatic logic [255:0] sha_compress(logic [255:0] h, logic [511:0] blk);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        logic [255:0] r;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = h[255 - 32 * i -: 32];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) r[255 - 32 * i -: 32] = h[255 - 32 * i -: 32] + v[i];
        return r;
    endfunction

    function automatic logic [255:0] seed_digest();
        return sha_compress(IV, {DOMAIN, 8'h80, 216'd0, 64'd224});
    endfunction

    // advance the chain digest for one accepted item, queue any read words
    task automatic predict_digest(in_item_t it);
        logic [63:0] w;
        case (it.kind)
            KIND_WORD, KIND_FLOAT: begin
                w = it.data_word;
                if (it.kind == KIND_FLOAT) begin
                    w = {32'd0, it.data_word[31:0]};
                    if (it.data_word[31:0] == NEG_ZERO) w = '0;
                end
                chain_q = sha_compress(IV, {chain_q, w, 8'h80, 120'd0, 64'd320});
            end
            KIND_PART: begin
                if (part_cnt < 3) begin
                    parts_q[part_cnt] = it.data_word;
                    part_cnt++;
                end else begin
                    chain_q = sha_compress(sha_compress(IV,
                        {chain_q, parts_q[0], parts_q[1], parts_q[2], it.data_word}),
                        {8'h80, 440'd0, 64'd512});
                    part_cnt = 0;
                end
            end
            KIND_READ: begin
                for (int k = 0; k < 4; k++)
                    digest_words_q.push_back('{digest_word: chain_q[255 - 64 * k -: 64],
                                               word_index: 2'(k), last: (k == 3)});
                reads_sent++;
            end
            KIND_RESTART: begin
                chain_q = seed_digest();
                part_cnt = 0;
            end
            default: ;
        endcase
    endtask

    task automatic push_item(logic [2:0] kind, logic [63:0] data, bit drain = 0);
        pend_t p;
        p.item.kind = kind;
        p.item.data_word = data;
        p.drain = drain;
        pend_q.push_back(p);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // sender: offers pending items, random gaps, optional drain before an item
    int  s_gap = 0;
    int  s_burst = 0;
    always @(posedge aclk) begin
        logic nv;
        pend_t p;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nv = s_valid;
            if (s_valid && s_ready) begin
                predict_digest(s_data);
                items_sent++;
                nv = 1'b0;
                if (s_burst > 0) begin
                    s_burst--;
                    s_gap = 0;
                end else begin
                    s_gap = $urandom_range(0, 11);
                    if ($urandom_range(0, 29) == 0) s_burst = 20;
                end
            end
            if (!nv) begin
                if (s_gap > 0) begin
                    s_gap--;
                end else if (pend_q.size() > 0 &&
                             (!pend_q[0].drain || digest_words_q.size() == 0)) begin
                    p = pend_q.pop_front();
                    s_data <= p.item;
                    nv = 1'b1;
                end
            end
            s_valid <= nv;
        end
    end

    // receiver: checks each transfer against the oldest expected digest word
    int  m_wait = 0;
    int  m_hold = 0;
    int  m_burst = 0;
    bit  hold_done = 0;
    always @(posedge aclk) begin
        logic nr;
        out_item_t exp_w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            nr = m_ready;
            if (m_valid && m_ready) begin
                if (digest_words_q.size() == 0) begin
                    $display("%0t: unexpected transfer, actual %h", $time, m_data);
                    errors++;
                end else begin
                    exp_w = digest_words_q.pop_front();
                    if (m_data.digest_word !== exp_w.digest_word) begin
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, exp_w.digest_word, m_data.digest_word);
                        errors++;
                    end
                    if (m_data.word_index !== exp_w.word_index) begin
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, exp_w.word_index, m_data.word_index);
                        errors++;
                    end
                    if (m_data.last !== exp_w.last) begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, exp_w.last, m_data.last);
                        errors++;
                    end
                end
                words_checked++;
                if (m_burst > 0) begin
                    m_burst--;
                    m_wait = 0;
                end else begin
                    m_wait = $urandom_range(0, 11);
                    if ($urandom_range(0, 29) == 0) m_burst = 24;
                end
                if (!hold_done && words_checked == 60) begin
                    m_hold = HOLD_CYCLES;
                    hold_done = 1;
                end
            end
            if (m_hold > 0) begin
                m_hold--;
                nr = 1'b0;
            end else if (m_wait > 0) begin
                m_wait--;
                nr = 1'b0;
            end else begin
                nr = 1'b1;
            end
            m_ready <= nr;
        end
    end

    // watchdog on cycles without any transfer
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int n, r, k;
        chain_q = seed_digest();
        part_cnt = 0;
        for (int i = 0; i < 3; i++) parts_q[i] = '0;

        // directed: field extremes, float special patterns, part staging, restart, reads and spare kinds
        push_item(KIND_READ, '0);
        push_item(KIND_WORD, '0);
        push_item(KIND_WORD, '1);
        push_item(KIND_FLOAT, 64'hffff_ffff_8000_0000);
        push_item(KIND_FLOAT, 64'h0000_0000_0000_0000);
        push_item(KIND_FLOAT, 64'h1234_5678_7fc0_0001);
        push_item(KIND_FLOAT, 64'h0000_0000_ffff_ffff);
        push_item(KIND_READ, '1);
        push_item(KIND_PART, '1);
        push_item(KIND_PART, '0);
        push_item(KIND_WORD, 64'h0123_4567_89ab_cdef);
        push_item(KIND_PART, 64'h8000_0000_0000_0001);
        push_item(KIND_READ, '0);
        push_item(KIND_PART, 64'hfedc_ba98_7654_3210);
        push_item(KIND_READ, '0);
        push_item(KIND_PART, 64'haaaa_aaaa_aaaa_aaaa);
        push_item(KIND_PART, 64'h5555_5555_5555_5555);
        push_item(KIND_RESTART, '1);
        push_item(KIND_READ, '0);
        push_item(KIND_SPARE_LO, '1);
        push_item(KIND_SPARE_MID, '1);
        push_item(KIND_SPARE_HI, 64'h1);
        push_item(KIND_READ, '0, 1);

        // random: mostly well-formed part groups and absorbs, some noise
        n = 0;
        while (n < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 22) begin
                push_item(KIND_WORD, rand64()); n++;
            end else if (r < 36) begin
                push_item(KIND_FLOAT, ($urandom_range(0, 3) == 0) ?
                          {$urandom, NEG_ZERO} : rand64()); n++;
            end else if (r < 52) begin
                for (int i = 0; i < 4; i++) push_item(KIND_PART, rand64());
                n += 4;
            end else if (r < 58) begin
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++) push_item(KIND_PART, rand64());
                n += k;
            end else if (r < 80) begin
                push_item(KIND_READ, rand64(), ($urandom_range(0, 39) == 0)); n++;
            end else if (r < 88) begin
                push_item(KIND_RESTART, rand64()); n++;
            end else if (r < 93) begin
                push_item(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), rand64());
            end else begin
                push_item(KIND_PART, rand64()); n++;
            end
            if (n >= 250 && n < 254) push_item(KIND_READ, rand64(), 1);
        end
        push_item(KIND_READ, '0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // drain all stimulus and results, then let the core settle
        while (pend_q.size() > 0 || s_valid || digest_words_q.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (digest_words_q.size() > 0) begin
            $display("%0t: %0d expected digest words never arrived",
                     $time, digest_words_q.size());
            errors++;
        end
        $display("covered %0d items (%0d reads), %0d digest words checked, %0d errors",
                 items_sent, reads_sent, words_checked, errors);
        $display("stimulus mixed word, float, staged part, restart and spare kinds");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
